FILE: sv/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, command codes, register indexes and sequencer phases.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   // Number of data bits in one bus byte.
   localparam int unsigned BITS_PER_BYTE = 8;

   // Command codes carried by the opcode field.
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_WAIT  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LONG_HOLD  = 2'd0;
   localparam logic [1:0] CSR_BIT_HOLD   = 2'd1;
   localparam logic [1:0] CSR_SHORT_HOLD = 2'd2;
   localparam logic [1:0] CSR_ACK_POLLS  = 2'd3;

   // Register reset values.
   localparam logic [7:0] LONG_HOLD_RESET  = 8'd4;
   localparam logic [7:0] BIT_HOLD_RESET   = 8'd2;
   localparam logic [7:0] SHORT_HOLD_RESET = 8'd1;
   localparam logic [7:0] ACK_POLLS_RESET  = 8'd250;

   // Sequencer phases: start, stop, wait ack, write bit, read bit, read ack.
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_ST1  = 4'd1,
      PH_ST2  = 4'd2,
      PH_SP1  = 4'd3,
      PH_SP2  = 4'd4,
      PH_WA1  = 4'd5,
      PH_WA2  = 4'd6,
      PH_WA3  = 4'd7,
      PH_WB0  = 4'd8,
      PH_WB1  = 4'd9,
      PH_WB2  = 4'd10,
      PH_RB0  = 4'd11,
      PH_RB1  = 4'd12,
      PH_RA0  = 4'd13,
      PH_RA1  = 4'd14
   } phase_type;

   // Configuration registers as seen by the sequencer.
   typedef struct packed {
      logic [7:0] long_hold_ticks;
      logic [7:0] bit_hold_ticks;
      logic [7:0] short_hold_ticks;
      logic [7:0] ack_timeout_polls;
   } cfg_type;

   // One input word: a tick with an optional command.
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] tx_data;
      logic       send_ack;
      logic       sda_in;
   } req_word_type;

   // One result word: line levels and status after the tick.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       ack_error;
   } rsp_word_type;

endpackage

FILE: sv/i2cmbe_if.sv
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------

// Input channel: one tick word per handshake.
interface i2cmbe_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] opcode;
   logic [7:0] tx_data;
   logic       send_ack;
   logic       sda_in;

   modport source (output valid, output cmd_valid, output opcode, output tx_data,
                   output send_ack, output sda_in, input ready);
   modport sink   (input valid, input cmd_valid, input opcode, input tx_data,
                   input send_ack, input sda_in, output ready);
endinterface

// Result channel: one result word per handshake.
interface i2cmbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_data;
   logic       ack_error;

   modport source (output valid, output scl_level, output sda_level, output sda_drive,
                   output busy_res, output done_res, output rx_data,
                   output ack_error, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
                   input busy_res, input done_res, input rx_data,
                   input ack_error, output ready);
endinterface

FILE: sv/i2c_master_bit_engine_top.sv
// A held input word steps the sequencer once the result register has room.
// Throughput: one tick word per cycle while rsp_chan.ready keeps up; the input
// and result registers let a new word enter while the previous result waits for ready.
// Reset (synchronous, active high) empties both registers, idles the sequencer
// with SCL high and SDA driven high, and loads the hold and timeout registers.
// ----------------------------------------------------------------------------
// I2C master bit engine top level
// Input word register, bus sequencer and result word register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top (
   input  logic        clock,
   input  logic        reset,
   i2cmbe_req_if.sink  req_chan,
   i2cmbe_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import i2cmbe_pkg::*;

   cfg_type      cfg;
   req_word_type in_word_ff, in_word_in;
   logic         in_valid_ff;
   rsp_word_type out_word_ff;
   logic         out_valid_ff;
   rsp_word_type core_result;
   logic         core_fire;
   logic         req_fire;

   i2cmbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer steps when a word is held and the result register has room.
   assign core_fire      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || core_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_word_in.cmd_valid = req_chan.cmd_valid;
      in_word_in.opcode    = req_chan.opcode;
      in_word_in.tx_data   = req_chan.tx_data;
      in_word_in.send_ack  = req_chan.send_ack;
      in_word_in.sda_in    = req_chan.sda_in;
   end

   i2cmbe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (core_fire),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // Input word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (core_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= in_word_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (core_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_fire) begin
         out_word_ff <= core_result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.scl_level = out_word_ff.scl_level;
   assign rsp_chan.sda_level = out_word_ff.sda_level;
   assign rsp_chan.sda_drive = out_word_ff.sda_drive;
   assign rsp_chan.busy_res  = out_word_ff.busy_res;
   assign rsp_chan.done_res  = out_word_ff.done_res;
   assign rsp_chan.rx_data   = out_word_ff.rx_data;
   assign rsp_chan.ack_error = out_word_ff.ack_error;

endmodule

FILE: sv/i2cmbe_csr.sv
// ----------------------------------------------------------------------------
// I2C master bit engine registers
// Hold and timeout registers written through the plain write port.
// ----------------------------------------------------------------------------
module i2cmbe_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output i2cmbe_pkg::cfg_type cfg
);
   import i2cmbe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index on a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_HOLD:  cfg_in.long_hold_ticks   = csr_wdata;
            CSR_BIT_HOLD:   cfg_in.bit_hold_ticks    = csr_wdata;
            CSR_SHORT_HOLD: cfg_in.short_hold_ticks  = csr_wdata;
            CSR_ACK_POLLS:  cfg_in.ack_timeout_polls = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_hold_ticks   <= LONG_HOLD_RESET;
         cfg_ff.bit_hold_ticks    <= BIT_HOLD_RESET;
         cfg_ff.short_hold_ticks  <= SHORT_HOLD_RESET;
         cfg_ff.ack_timeout_polls <= ACK_POLLS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/i2cmbe_core.sv
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Bus phase state machine: advances one tick per step and forms the result.
// ----------------------------------------------------------------------------
module i2cmbe_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  i2cmbe_pkg::req_word_type item,
   input  i2cmbe_pkg::cfg_type      cfg,
   output i2cmbe_pkg::rsp_word_type result
);
   import i2cmbe_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] hold_ff, hold_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] poll_ff, poll_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       drv_ff, drv_in;
   logic       ack_ff, ack_in;
   logic       err_ff, err_in;
   logic [7:0] rx_ff, rx_in;
   logic       done_in;
   logic [7:0] hold_inc;
   logic [7:0] hold_lim;
   logic [3:0] bit_inc;
   logic [7:0] shift_up;

   // Hold length of the current phase.
   always_comb begin
      unique case (phase_ff)
         PH_ST1, PH_ST2, PH_SP1, PH_SP2: hold_lim = cfg.long_hold_ticks;
         PH_WA1, PH_WA2, PH_RB1:         hold_lim = cfg.short_hold_ticks;
         default:                        hold_lim = cfg.bit_hold_ticks;
      endcase
   end

   assign hold_inc = hold_ff + 8'd1;
   assign bit_inc  = bit_ff + 4'd1;
   assign shift_up = {shift_ff[6:0], 1'b0};

   // Next state for one tick.
   always_comb begin
      phase_in = phase_ff;
      hold_in  = hold_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drv_in   = drv_ff;
      ack_in   = ack_ff;
      err_in   = err_ff;
      rx_in    = rx_ff;
      done_in  = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (item.cmd_valid) begin
                  hold_in = 8'd0;
                  unique case (item.opcode)
                     OP_START: begin
                        scl_in = 1'b1; sda_in = 1'b1; drv_in = 1'b1;
                        phase_in = PH_ST1;
                     end
                     OP_STOP: begin
                        scl_in = 1'b0; sda_in = 1'b0; drv_in = 1'b1;
                        phase_in = PH_SP1;
                     end
                     OP_WRITE: begin
                        shift_in = item.tx_data;
                        bit_in   = 4'd0;
                        scl_in   = 1'b0;
                        sda_in   = item.tx_data[7];
                        drv_in   = 1'b1;
                        phase_in = PH_WB0;
                     end
                     OP_WAIT: begin
                        err_in   = 1'b0;
                        poll_in  = 8'd0;
                        sda_in   = 1'b1;
                        drv_in   = 1'b0;
                        phase_in = PH_WA1;
                     end
                     OP_READ: begin
                        shift_in = 8'd0;
                        bit_in   = 4'd0;
                        ack_in   = item.send_ack;
                        scl_in   = 1'b0; sda_in = 1'b1; drv_in = 1'b0;
                        phase_in = PH_RB0;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
            PH_WA3: begin
               // Poll SDA each tick until the slave pulls it low or time runs out.
               if (!item.sda_in) begin
                  scl_in   = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else if (poll_ff >= cfg.ack_timeout_polls) begin
                  err_in   = 1'b1;
                  hold_in  = 8'd0;
                  scl_in   = 1'b0; sda_in = 1'b0; drv_in = 1'b1;
                  phase_in = PH_SP1;
               end else begin
                  poll_in = poll_ff + 8'd1;
               end
            end
            default: begin
               hold_in = hold_inc;
               if (hold_inc >= hold_lim) begin
                  hold_in = 8'd0;
                  unique case (phase_ff)
                     PH_ST1: begin sda_in = 1'b0; phase_in = PH_ST2; end
                     PH_ST2: begin
                        scl_in = 1'b0; phase_in = PH_IDLE; done_in = 1'b1;
                     end
                     PH_SP1: begin
                        scl_in = 1'b1; sda_in = 1'b1; phase_in = PH_SP2;
                     end
                     PH_SP2: begin phase_in = PH_IDLE; done_in = 1'b1; end
                     PH_WA1: begin scl_in = 1'b1; phase_in = PH_WA2; end
                     PH_WA2: phase_in = PH_WA3;
                     PH_WB0: begin scl_in = 1'b1; phase_in = PH_WB1; end
                     PH_WB1: begin scl_in = 1'b0; phase_in = PH_WB2; end
                     PH_WB2: begin
                        shift_in = shift_up;
                        bit_in   = bit_inc;
                        if (32'(bit_inc) < BITS_PER_BYTE) begin
                           sda_in   = shift_up[7];
                           phase_in = PH_WB0;
                        end else begin
                           phase_in = PH_IDLE;
                           done_in  = 1'b1;
                        end
                     end
                     PH_RB0: begin
                        // Sample SDA as SCL rises.
                        scl_in   = 1'b1;
                        shift_in = {shift_ff[6:0], item.sda_in};
                        phase_in = PH_RB1;
                     end
                     PH_RB1: begin
                        bit_in = bit_inc;
                        if (32'(bit_inc) < BITS_PER_BYTE) begin
                           scl_in   = 1'b0;
                           phase_in = PH_RB0;
                        end else begin
                           scl_in   = 1'b0;
                           sda_in   = ~ack_ff;
                           drv_in   = 1'b1;
                           phase_in = PH_RA0;
                        end
                     end
                     PH_RA0: begin scl_in = 1'b1; phase_in = PH_RA1; end
                     PH_RA1: begin
                        scl_in   = 1'b0;
                        rx_in    = shift_ff;
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hold_ff  <= 8'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         poll_ff  <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         err_ff   <= 1'b0;
         rx_ff    <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         poll_ff  <= poll_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drv_ff   <= drv_in;
         ack_ff   <= ack_in;
         err_ff   <= err_in;
         rx_ff    <= rx_in;
      end
   end

   // Result word reflects the state after this tick.
   always_comb begin
      result.scl_level = scl_in;
      result.sda_level = sda_in;
      result.sda_drive = drv_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done_in;
      result.rx_data   = rx_in;
      result.ack_error = err_in;
   end

endmodule

FILE: sv/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_sda_level,
   input logic rsp_sda_drive,
   input logic rsp_busy_res,
   input logic rsp_done_res
);

   // A result word offered and not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   // No result word is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered after reset");

   // A completing word always shows the engine idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done pulse while still busy");

   // Released SDA reads as high.
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_sda_level)
      else $error("released SDA level not high");

endmodule

bind i2c_master_bit_engine_top i2cmbe_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_sda_level (rsp_chan.sda_level),
   .rsp_sda_drive (rsp_chan.sda_drive),
   .rsp_busy_res  (rsp_chan.busy_res),
   .rsp_done_res  (rsp_chan.done_res)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives one tick word per handshake into the engine and predicts the line
// levels and status of every result word. A small scoreboard class keeps its
// own copy of the sequencer state and compares each result word field by
// field. Directed commands run first and last, random bus transfers between.
// Several register settings are covered, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import i2cmbe_pkg::*;

   // Cycles without any handshake before the run is declared hung.
   localparam int IDLE_LIMIT = 4000;

   // How SDA answers during an ack wait.
   typedef enum {ACK_AT_ONCE, ACK_QUICK, ACK_SLOW, ACK_NEVER} ack_mode_type;

   // Predicts the result word of every accepted tick word and checks the
   // result words against the predictions in order.
   class bus_line_predictor;
      cfg_type      cfg;
      phase_type    ph;
      logic [7:0]   hold_cnt;
      logic [3:0]   bits;
      logic [7:0]   shifter;
      logic [7:0]   polls;
      logic         scl;
      logic         sda;
      logic         drv;
      logic         ack_sel;
      logic         err;
      logic [7:0]   rx;
      rsp_word_type expected_words[$];
      int           errors;
      int           ticks;
      int           checked;
      int           timeouts;
      int           ignored;
      int           begun[5];

      function new();
         cfg.long_hold_ticks   = LONG_HOLD_RESET;
         cfg.bit_hold_ticks    = BIT_HOLD_RESET;
         cfg.short_hold_ticks  = SHORT_HOLD_RESET;
         cfg.ack_timeout_polls = ACK_POLLS_RESET;
         ph       = PH_IDLE;
         hold_cnt = '0;
         bits     = '0;
         shifter  = '0;
         polls    = '0;
         scl      = 1'b1;
         sda      = 1'b1;
         drv      = 1'b1;
         ack_sel  = 1'b0;
         err      = 1'b0;
         rx       = '0;
      endfunction

      function void set_reg(logic [1:0] index, logic [7:0] value);
         case (index)
            CSR_LONG_HOLD:  cfg.long_hold_ticks   = value;
            CSR_BIT_HOLD:   cfg.bit_hold_ticks    = value;
            CSR_SHORT_HOLD: cfg.short_hold_ticks  = value;
            CSR_ACK_POLLS:  cfg.ack_timeout_polls = value;
            default: ;
         endcase
      endfunction

      function bit is_idle();
         return ph == PH_IDLE;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void set_lines(logic c, logic d, logic e);
         scl = c;
         sda = d;
         drv = e;
      endfunction

      // Number of ticks each line state is held.
      function logic [7:0] hold_of(phase_type p);
         case (p)
            PH_ST1, PH_ST2, PH_SP1, PH_SP2: return cfg.long_hold_ticks;
            PH_WA1, PH_WA2, PH_RB1:         return cfg.short_hold_ticks;
            default:                        return cfg.bit_hold_ticks;
         endcase
      endfunction

      // Advances the sequencer by one tick and queues the result word.
      function void note_tick(req_word_type w);
         rsp_word_type e;
         logic         fin;
         fin = 1'b0;
         ticks++;
         if (ph != PH_IDLE && w.cmd_valid) ignored++;
         if (ph == PH_IDLE) begin
            if (w.cmd_valid) begin
               hold_cnt = '0;
               case (w.opcode)
                  OP_START: begin
                     set_lines(1'b1, 1'b1, 1'b1);
                     ph = PH_ST1;
                  end
                  OP_STOP: begin
                     set_lines(1'b0, 1'b0, 1'b1);
                     ph = PH_SP1;
                  end
                  OP_WRITE: begin
                     shifter = w.tx_data;
                     bits    = '0;
                     set_lines(1'b0, w.tx_data[7], 1'b1);
                     ph = PH_WB0;
                  end
                  OP_WAIT: begin
                     err   = 1'b0;
                     polls = '0;
                     set_lines(scl, 1'b1, 1'b0);
                     ph = PH_WA1;
                  end
                  OP_READ: begin
                     shifter = '0;
                     bits    = '0;
                     ack_sel = w.send_ack;
                     set_lines(1'b0, 1'b1, 1'b0);
                     ph = PH_RB0;
                  end
                  default: ignored++;
               endcase
               if (ph != PH_IDLE) begun[w.opcode]++;
            end
         end else if (ph == PH_WA3) begin
            // One poll of SDA per tick; a timeout turns into a stop.
            if (!w.sda_in) begin
               scl = 1'b0;
               ph  = PH_IDLE;
               fin = 1'b1;
            end else if (polls >= cfg.ack_timeout_polls) begin
               err      = 1'b1;
               hold_cnt = '0;
               set_lines(1'b0, 1'b0, 1'b1);
               ph = PH_SP1;
               timeouts++;
            end else begin
               polls = polls + 8'd1;
            end
         end else begin
            hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt >= hold_of(ph)) begin
               hold_cnt = '0;
               case (ph)
                  PH_ST1: begin
                     sda = 1'b0;
                     ph  = PH_ST2;
                  end
                  PH_ST2: begin
                     scl = 1'b0;
                     ph  = PH_IDLE;
                     fin = 1'b1;
                  end
                  PH_SP1: begin
                     scl = 1'b1;
                     sda = 1'b1;
                     ph  = PH_SP2;
                  end
                  PH_SP2: begin
                     ph  = PH_IDLE;
                     fin = 1'b1;
                  end
                  PH_WA1: begin
                     scl = 1'b1;
                     ph  = PH_WA2;
                  end
                  PH_WA2: ph = PH_WA3;
                  PH_WB0: begin
                     scl = 1'b1;
                     ph  = PH_WB1;
                  end
                  PH_WB1: begin
                     scl = 1'b0;
                     ph  = PH_WB2;
                  end
                  PH_WB2: begin
                     shifter = shifter << 1;
                     bits    = bits + 4'd1;
                     if (bits < BITS_PER_BYTE) begin
                        sda = shifter[7];
                        ph  = PH_WB0;
                     end else begin
                        ph  = PH_IDLE;
                        fin = 1'b1;
                     end
                  end
                  PH_RB0: begin
                     scl     = 1'b1;
                     shifter = {shifter[6:0], w.sda_in};
                     ph      = PH_RB1;
                  end
                  PH_RB1: begin
                     bits = bits + 4'd1;
                     if (bits < BITS_PER_BYTE) begin
                        scl = 1'b0;
                        ph  = PH_RB0;
                     end else begin
                        set_lines(1'b0, !ack_sel, 1'b1);
                        ph = PH_RA0;
                     end
                  end
                  PH_RA0: begin
                     scl = 1'b1;
                     ph  = PH_RA1;
                  end
                  PH_RA1: begin
                     scl = 1'b0;
                     rx  = shifter;
                     ph  = PH_IDLE;
                     fin = 1'b1;
                  end
                  default: ph = PH_IDLE;
               endcase
            end
         end
         e.scl_level = scl;
         e.sda_level = sda;
         e.sda_drive = drv;
         e.busy_res  = (ph != PH_IDLE);
         e.done_res  = fin;
         e.rx_data   = rx;
         e.ack_error = err;
         expected_words.push_back(e);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compares one result word with the oldest prediction.
      function void check_lines(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word arrived with no prediction waiting");
            errors++;
            return;
         end
         want = expected_words.pop_front();
         checked++;
         compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
         compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
         compare_field("busy_res",  8'(want.busy_res),  8'(got.busy_res));
         compare_field("done_res",  8'(want.done_res),  8'(got.done_res));
         compare_field("rx_data",   want.rx_data,       got.rx_data);
         compare_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [7:0]   csr_wdata;

   i2cmbe_req_if req_chan ();
   i2cmbe_rsp_if rsp_chan ();

   bus_line_predictor bus_lines;
   ack_mode_type      ack_mode = ACK_QUICK;
   logic [2:0]        plan[$];
   int                send_burst = 0;
   int                settings = 0;
   int                hold_offs = 0;
   bit                hold_off_req = 1'b0;
   int                idle_cycles = 0;

   i2c_master_bit_engine_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap length: mostly short, a few long, with occasional bursts of none.
   function automatic int pick_gap(inout int burst);
      int roll;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll == 0) begin
         burst = $urandom_range(80, 30);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 96) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // A tick word with no command; SDA answers an ack wait as the mode says.
   function automatic req_word_type filler_tick();
      req_word_type w;
      w.cmd_valid = 1'b0;
      w.opcode    = 3'($urandom_range(7));
      w.tx_data   = 8'($urandom_range(255));
      w.send_ack  = 1'($urandom_range(1));
      w.sda_in    = 1'($urandom_range(1));
      if (bus_lines.ph == PH_WA3) begin
         case (ack_mode)
            ACK_AT_ONCE: w.sda_in = 1'b0;
            ACK_QUICK:   w.sda_in = 1'($urandom_range(1));
            ACK_SLOW:    w.sda_in = ($urandom_range(15) != 0);
            default:     w.sda_in = 1'b1;
         endcase
      end
      return w;
   endfunction

   // Random tick word: mostly commands from well-formed transfers when idle,
   // some bad opcodes and idle ticks, and a little noise while busy.
   function automatic req_word_type make_tick();
      req_word_type w;
      int           roll;
      int           never_pct;
      w = filler_tick();
      if (bus_lines.is_idle()) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            w.cmd_valid = 1'b0;
         end else if (roll < 17) begin
            w.cmd_valid = 1'b1;
            w.opcode    = 3'($urandom_range(7, OP_READ + 1));
         end else begin
            if (plan.size() == 0) begin
               if ($urandom_range(4) == 0) begin
                  plan.push_back(3'($urandom_range(OP_READ, OP_START)));
               end else begin
                  plan.push_back(OP_START);
                  plan.push_back(OP_WRITE);
                  plan.push_back(OP_WAIT);
                  repeat ($urandom_range(3, 1)) begin
                     if ($urandom_range(1)) begin
                        plan.push_back(OP_WRITE);
                        plan.push_back(OP_WAIT);
                     end else begin
                        plan.push_back(OP_READ);
                     end
                  end
                  plan.push_back(OP_STOP);
               end
            end
            w.cmd_valid = 1'b1;
            w.opcode    = plan.pop_front();
            if (w.opcode == OP_WAIT) begin
               // Timeouts are rarer when the poll limit is large.
               never_pct = (bus_lines.cfg.ack_timeout_polls > 40) ? 3 : 15;
               roll = $urandom_range(99);
               if (roll < 10)                  ack_mode = ACK_AT_ONCE;
               else if (roll < 55)             ack_mode = ACK_QUICK;
               else if (roll < 100 - never_pct) ack_mode = ACK_SLOW;
               else                            ack_mode = ACK_NEVER;
            end
         end
      end else begin
         w.cmd_valid = ($urandom_range(9) == 0);
      end
      return w;
   endfunction

   // Lowers valid for the gap of length n, starting at the current falling edge.
   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Offers one tick word and returns at the falling edge after it is taken.
   task automatic send_tick(input req_word_type w);
      req_chan.valid     <= 1'b1;
      req_chan.cmd_valid <= w.cmd_valid;
      req_chan.opcode    <= w.opcode;
      req_chan.tx_data   <= w.tx_data;
      req_chan.send_ack  <= w.send_ack;
      req_chan.sda_in    <= w.sda_in;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Issues one command and feeds ticks until the sequence is over. A noisy
   // command gets extra commands thrown at it while busy.
   task automatic issue(input logic [2:0] op, input logic [7:0] data, input logic ack,
                        input ack_mode_type mode, input bit noisy);
      req_word_type w;
      ack_mode    = mode;
      w           = filler_tick();
      w.cmd_valid = 1'b1;
      w.opcode    = op;
      w.tx_data   = data;
      w.send_ack  = ack;
      idle_gap(pick_gap(send_burst));
      send_tick(w);
      while (!bus_lines.is_idle()) begin
         w = filler_tick();
         if (noisy) w.cmd_valid = 1'b1;
         idle_gap(pick_gap(send_burst));
         send_tick(w);
      end
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      bus_lines.set_reg(index, value);
      @(negedge clock);
   endtask

   // Loads all four registers once every outstanding result word is back.
   task automatic write_regs(input logic [7:0] lh, input logic [7:0] bh,
                             input logic [7:0] sh, input logic [7:0] ap);
      req_chan.valid <= 1'b0;
      while (bus_lines.pending() > 0) @(negedge clock);
      repeat (2) @(negedge clock);
      write_csr(CSR_LONG_HOLD, lh);
      write_csr(CSR_BIT_HOLD, bh);
      write_csr(CSR_SHORT_HOLD, sh);
      write_csr(CSR_ACK_POLLS, ap);
      csr_we <= 1'b0;
      settings++;
   endtask

   // Random transfers for about n ticks, then idle ticks until the engine stops.
   task automatic random_phase(input int n, input bit squeeze);
      req_word_type w;
      int           sent;
      if (squeeze) hold_off_req = 1'b1;
      sent = 0;
      while (sent < n || !bus_lines.is_idle()) begin
         idle_gap(pick_gap(send_burst));
         w = (sent < n) ? make_tick() : filler_tick();
         send_tick(w);
         sent++;
      end
   endtask

   // Result side: random ready gaps, plus a long hold-off on request.
   initial begin
      int wait_left;
      int burst;
      wait_left = 0;
      burst     = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            wait_left    = 400;
            hold_offs++;
         end
         if (wait_left > 0) begin
            rsp_chan.ready <= 1'b0;
            wait_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            wait_left = pick_gap(burst);
         end
      end
   end

   // Sample both channels at the rising edge and watch for a hang.
   always @(posedge clock) begin
      req_word_type tick;
      rsp_word_type lines;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            tick.cmd_valid = req_chan.cmd_valid;
            tick.opcode    = req_chan.opcode;
            tick.tx_data   = req_chan.tx_data;
            tick.send_ack  = req_chan.send_ack;
            tick.sda_in    = req_chan.sda_in;
            bus_lines.note_tick(tick);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            lines.scl_level = rsp_chan.scl_level;
            lines.sda_level = rsp_chan.sda_level;
            lines.sda_drive = rsp_chan.sda_drive;
            lines.busy_res  = rsp_chan.busy_res;
            lines.done_res  = rsp_chan.done_res;
            lines.rx_data   = rsp_chan.rx_data;
            lines.ack_error = rsp_chan.ack_error;
            bus_lines.check_lines(lines);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      bus_lines          = new();
      req_chan.valid     <= 1'b0;
      req_chan.cmd_valid <= 1'b0;
      req_chan.opcode    <= OP_START;
      req_chan.tx_data   <= 8'h00;
      req_chan.send_ack  <= 1'b0;
      req_chan.sda_in    <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_LONG_HOLD;
      csr_wdata          <= 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands at the reset settings.
      issue(OP_START, 8'h00, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_WRITE, 8'hFF, 1'b1, ACK_QUICK, 1'b0);
      issue(OP_WAIT,  8'h00, 1'b0, ACK_AT_ONCE, 1'b0);
      issue(OP_WRITE, 8'h00, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_WAIT,  8'hFF, 1'b1, ACK_QUICK, 1'b0);
      issue(OP_READ,  8'h00, 1'b1, ACK_QUICK, 1'b0);
      issue(OP_READ,  8'hFF, 1'b0, ACK_QUICK, 1'b0);
      // An ack that never comes ends in a stop with the error flag set,
      // and the next wait clears the flag.
      issue(OP_WAIT,  8'h00, 1'b0, ACK_NEVER, 1'b0);
      issue(OP_WAIT,  8'h00, 1'b0, ACK_SLOW, 1'b0);
      issue(OP_STOP,  8'h00, 1'b0, ACK_QUICK, 1'b0);
      // Opcodes past the last command are ignored.
      issue(3'(OP_READ + 1), 8'hFF, 1'b1, ACK_QUICK, 1'b0);
      issue(3'(OP_READ + 2), 8'h00, 1'b0, ACK_QUICK, 1'b0);
      issue(3'(OP_READ + 3), 8'hFF, 1'b1, ACK_QUICK, 1'b0);
      // Commands while busy are ignored.
      issue(OP_START, 8'h00, 1'b0, ACK_QUICK, 1'b1);
      issue(OP_WRITE, 8'hA5, 1'b0, ACK_QUICK, 1'b1);
      issue(OP_STOP,  8'h00, 1'b0, ACK_QUICK, 1'b0);

      // Zero registers: every hold lasts one tick, the first high poll fails.
      write_regs(8'd0, 8'd0, 8'd0, 8'd0);
      issue(OP_START, 8'h00, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_WRITE, 8'h81, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_WAIT,  8'h00, 1'b0, ACK_NEVER, 1'b0);
      issue(OP_WAIT,  8'h00, 1'b0, ACK_AT_ONCE, 1'b0);
      issue(OP_READ,  8'h00, 1'b1, ACK_QUICK, 1'b0);
      issue(OP_STOP,  8'h00, 1'b0, ACK_QUICK, 1'b0);

      // Random transfers over several settings.
      write_regs(8'd1, 8'd1, 8'd1, 8'd1);
      random_phase(120, 1'b0);
      write_regs(8'($urandom_range(8, 1)), 8'($urandom_range(4, 1)),
                 8'($urandom_range(4, 1)), 8'($urandom_range(12, 1)));
      random_phase(120, 1'b1);
      write_regs(8'($urandom_range(8, 1)), 8'($urandom_range(4, 1)),
                 8'($urandom_range(4, 1)), 8'($urandom_range(12, 1)));
      random_phase(120, 1'b0);
      write_regs(8'd3, 8'd2, 8'd1, 8'd250);
      random_phase(120, 1'b1);
      write_regs(8'($urandom_range(8, 1)), 8'($urandom_range(4, 1)),
                 8'($urandom_range(4, 1)), 8'($urandom_range(12, 1)));
      random_phase(120, 1'b0);

      // Largest timeout register: an ack that never comes polls all the way.
      write_regs(8'd1, 8'd1, 8'd1, 8'd255);
      issue(OP_START, 8'h00, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_WRITE, 8'h5A, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_WAIT,  8'h00, 1'b0, ACK_NEVER, 1'b0);
      issue(OP_READ,  8'h00, 1'b0, ACK_QUICK, 1'b0);
      issue(OP_STOP,  8'h00, 1'b0, ACK_QUICK, 1'b0);

      // Drain the result side, then allow a few more cycles.
      req_chan.valid <= 1'b0;
      while (bus_lines.pending() > 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Run covered %0d tick words and %0d result words over %0d settings.",
               bus_lines.ticks, bus_lines.checked, settings + 1);
      $display("Begun: start %0d, stop %0d, write %0d, wait %0d, read %0d.",
               bus_lines.begun[OP_START], bus_lines.begun[OP_STOP],
               bus_lines.begun[OP_WRITE], bus_lines.begun[OP_WAIT],
               bus_lines.begun[OP_READ]);
      $display("Ack timeouts %0d, ignored commands %0d, hold-offs %0d.",
               bus_lines.timeouts, bus_lines.ignored, hold_offs);
      if (bus_lines.errors == 0 && bus_lines.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
